// ===== rtl/nkpg_pkg.sv =====
// ----------------------------------------------------------------------------
// nkpg_pkg
// Shared types and constants of the next k-permutation generator: register
// indexes, field widths and the command and status bundles that connect the
// controller to the datapath.
// ----------------------------------------------------------------------------
package nkpg_pkg;

	// Default number of indices the store can hold.
	localparam int DEF_MAX_ITEMS = 16;

	// Configuration port.
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	// Stream payload widths.
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;
	localparam int ELEM_W     = 4;
	localparam int POS_W      = 4;

	// At most this many results follow one input transaction.
	localparam int RESULT_LIMIT = 16;

	// Register reset values.
	localparam logic [CFG_W-1:0] ITEM_COUNT_RST    = 5'd16;
	localparam logic [CFG_W-1:0] PREFIX_LENGTH_RST = 5'd16;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ITEM_COUNT    = 1'b0,
		REG_PREFIX_LENGTH = 1'b1
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;    // Latch the run's sizes and clear the value mask.
		logic restart;  // Together with start: reload the identity.
		logic sfx_rd;   // Read the next suffix entry into the value mask.
		logic sfx_end;  // Suffix done; point at the last prefix position.
		logic piv_rd;   // Read the pivot candidate.
		logic piv_cmp;  // Compare the candidate against its right neighbor.
		logic succ;     // Step the successor value search.
		logic wr_asc;   // Write the remaining values in ascending order.
		logic wr_desc;  // Write all values in descending order.
		logic emit_rd;  // Read the next prefix entry for output.
		logic emit_ld;  // Load a prefix result into the output register.
		logic exh_ld;   // Load the exhausted result into the output register.
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic m_lt_n;     // The requested prefix is shorter than the item count.
		logic sfx_last;   // The suffix read pointer is at the last entry.
		logic piv_found;  // The candidate is smaller than its right neighbor.
		logic piv_first;  // The candidate is at position zero.
		logic succ_hit;   // The search value is present in the mask.
		logic wr_done;    // The write pointer has reached the item count.
		logic last_pos;   // The emit pointer is at the last prefix position.
		logic out_free;   // The output register can take a result.
	} sts_t;

endpackage

// ===== rtl/nkpg_store.sv =====
// ----------------------------------------------------------------------------
// nkpg_store
// Permutation store: one write port and one registered read port. A valid
// bit per entry lets a clear of all valid bits bring back the identity,
// since an entry not written since the clear reads as its own address.
// ----------------------------------------------------------------------------
module nkpg_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [AW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] wr_data
);

	logic [AW-1:0]    mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [AW-1:0]    rd_q;

	// Valid bits: cleared by reset or restart, set by a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= vld_q[rd_addr] ? mem_q[rd_addr] : rd_addr;
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/nkpg_dp.sv =====
// ----------------------------------------------------------------------------
// nkpg_dp
// Datapath: size clamping, the permutation store, a bit mask of the values
// held in the tail of the arrangement, the scan pointers and the output
// register. Sorting is done by sweeping the mask, since the stored values
// are always distinct.
// ----------------------------------------------------------------------------
module nkpg_dp
	import nkpg_pkg::*;
#(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [CFG_W-1:0]      item_count,
	input  logic [CFG_W-1:0]      prefix_length,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	output logic [0:0]            m_tuser
);

	localparam int AW    = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [MAX_ITEMS-1:0] ONE = MAX_ITEMS'(1);

	// Clamped sizes for the next run.
	logic [CMP_W-1:0] ic_w;
	logic [CMP_W-1:0] pl_w;
	logic [CMP_W-1:0] lim_w;
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] m_eff;

	// Run state.
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     m_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     val_q;
	logic [MAX_ITEMS-1:0] mask_q;
	logic [AW-1:0]        prev_q;
	logic                 has_prev_q;
	logic [AW-1:0]        pv_q;
	logic [AW-1:0]        jpos_q;
	logic                 sfx_vld_q;

	// Output register.
	logic              out_vld_q;
	logic [ELEM_W-1:0] out_elem_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_last_q;
	logic              out_exh_q;

	// Store port signals.
	logic          st_rd_en;
	logic [AW-1:0] st_rd_data;
	logic          st_wr_en;
	logic [AW-1:0] st_wr_addr;
	logic [AW-1:0] val_idx;
	logic          mask_hit;

	// Clamp item count to 1..MAX_ITEMS and the prefix to 1..min(n, limit).
	always_comb begin
		ic_w = CMP_W'(item_count);
		pl_w = CMP_W'(prefix_length);
		if (ic_w == '0) begin
			n_eff = CNT_W'(1);
		end else if (ic_w > CMP_W'(MAX_ITEMS)) begin
			n_eff = CNT_W'(MAX_ITEMS);
		end else begin
			n_eff = ic_w[CNT_W-1:0];
		end
		lim_w = (CMP_W'(n_eff) < CMP_W'(RESULT_LIMIT)) ? CMP_W'(n_eff)
			: CMP_W'(RESULT_LIMIT);
		if (pl_w == '0) begin
			m_eff = CNT_W'(1);
		end else if (pl_w > lim_w) begin
			m_eff = lim_w[CNT_W-1:0];
		end else begin
			m_eff = pl_w[CNT_W-1:0];
		end
	end

	assign val_idx  = val_q[AW-1:0];
	assign mask_hit = mask_q[val_idx];

	// Status toward the controller.
	always_comb begin
		sts.m_lt_n    = (m_eff < n_eff);
		sts.sfx_last  = (ptr_q == n_q - CNT_W'(1));
		sts.piv_found = has_prev_q && (st_rd_data < prev_q);
		sts.piv_first = (ptr_q == '0);
		sts.succ_hit  = mask_hit;
		sts.wr_done   = (ptr_q == n_q);
		sts.last_pos  = (ptr_q == m_q - CNT_W'(1));
		sts.out_free  = !out_vld_q || m_tready;
	end

	// Store access: all reads and sequential writes go through ptr_q.
	assign st_rd_en   = cmd.sfx_rd || cmd.piv_rd || cmd.emit_rd;
	assign st_wr_en   = (cmd.succ && mask_hit)
		|| ((cmd.wr_asc || cmd.wr_desc) && !sts.wr_done && mask_hit);
	assign st_wr_addr = cmd.succ ? jpos_q : ptr_q[AW-1:0];

	nkpg_store #(
		.DEPTH(MAX_ITEMS),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cmd.start && cmd.restart),
		.rd_en  (st_rd_en),
		.rd_addr(ptr_q[AW-1:0]),
		.rd_data(st_rd_data),
		.wr_en  (st_wr_en),
		.wr_addr(st_wr_addr),
		.wr_data(val_idx)
	);

	// Marks a suffix read whose data arrives in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfx_vld_q <= 1'b0;
		end else begin
			sfx_vld_q <= cmd.sfx_rd;
		end
	end

	// Scan pointers, value mask and pivot bookkeeping.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q        <= n_eff;
			m_q        <= m_eff;
			mask_q     <= '0;
			has_prev_q <= 1'b0;
			ptr_q      <= cmd.restart ? '0 : m_eff;
		end else begin
			// Gather the suffix values; prev_q ends as their maximum.
			if (sfx_vld_q) begin
				mask_q <= mask_q | (ONE << st_rd_data);
				if (!has_prev_q || (st_rd_data > prev_q)) begin
					prev_q <= st_rd_data;
				end
				has_prev_q <= 1'b1;
			end
			if (cmd.sfx_rd) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.sfx_end) begin
				ptr_q <= m_q - CNT_W'(1);
			end
			// Walk left until an entry is smaller than its right neighbor.
			if (cmd.piv_cmp) begin
				if (sts.piv_found) begin
					pv_q   <= st_rd_data;
					jpos_q <= ptr_q[AW-1:0];
					val_q  <= CNT_W'(st_rd_data) + CNT_W'(1);
				end else begin
					mask_q     <= mask_q | (ONE << st_rd_data);
					prev_q     <= st_rd_data;
					has_prev_q <= 1'b1;
					if (sts.piv_first) begin
						val_q <= CNT_W'(MAX_ITEMS - 1);
					end else begin
						ptr_q <= ptr_q - CNT_W'(1);
					end
				end
			end
			// Smallest tail value above the pivot replaces the pivot.
			if (cmd.succ) begin
				if (mask_hit) begin
					mask_q <= (mask_q & ~(ONE << val_idx)) | (ONE << pv_q);
					ptr_q  <= CNT_W'(jpos_q) + CNT_W'(1);
					val_q  <= '0;
				end else begin
					val_q <= val_q + CNT_W'(1);
				end
			end
			// Lay the tail out in ascending order, then rewind for output.
			if (cmd.wr_asc) begin
				if (!sts.wr_done) begin
					if (mask_hit) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					val_q <= val_q + CNT_W'(1);
				end else begin
					ptr_q <= '0;
				end
			end
			// No successor: the whole arrangement in descending order.
			if (cmd.wr_desc && !sts.wr_done) begin
				if (mask_hit) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				val_q <= val_q - CNT_W'(1);
			end
			if (cmd.emit_ld && sts.out_free) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((cmd.emit_ld || cmd.exh_ld) && sts.out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_ld && sts.out_free) begin
			out_elem_q <= ELEM_W'(st_rd_data);
			out_pos_q  <= POS_W'(ptr_q);
			out_last_q <= sts.last_pos;
			out_exh_q  <= 1'b0;
		end else if (cmd.exh_ld && sts.out_free) begin
			out_elem_q <= '0;
			out_pos_q  <= '0;
			out_last_q <= 1'b1;
			out_exh_q  <= 1'b1;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = {out_pos_q, out_elem_q};
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_exh_q;

endmodule

// ===== rtl/nkpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// nkpg_ctrl
// Controller: sequences suffix gathering, pivot search, successor search,
// rewrite sweeps and result emission for one input transaction at a time.
// ----------------------------------------------------------------------------
module nkpg_ctrl
	import nkpg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic restart,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SFX,
		ST_SFX_END,
		ST_PIV_RD,
		ST_PIV_CMP,
		ST_SUCC,
		ST_WR_ASC,
		ST_WR_DESC,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EXH_LD
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	// Commands and next state.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.start   = 1'b1;
					cmd.restart = restart;
					if (restart) begin
						state_d = ST_EMIT_RD;
					end else if (sts.m_lt_n) begin
						state_d = ST_SFX;
					end else begin
						state_d = ST_SFX_END;
					end
				end
			end
			ST_SFX: begin
				cmd.sfx_rd = 1'b1;
				if (sts.sfx_last) begin
					state_d = ST_SFX_END;
				end
			end
			ST_SFX_END: begin
				cmd.sfx_end = 1'b1;
				state_d     = ST_PIV_RD;
			end
			ST_PIV_RD: begin
				cmd.piv_rd = 1'b1;
				state_d    = ST_PIV_CMP;
			end
			ST_PIV_CMP: begin
				cmd.piv_cmp = 1'b1;
				if (sts.piv_found) begin
					state_d = ST_SUCC;
				end else if (sts.piv_first) begin
					state_d = ST_WR_DESC;
				end else begin
					state_d = ST_PIV_RD;
				end
			end
			ST_SUCC: begin
				cmd.succ = 1'b1;
				if (sts.succ_hit) begin
					state_d = ST_WR_ASC;
				end
			end
			ST_WR_ASC: begin
				cmd.wr_asc = 1'b1;
				if (sts.wr_done) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_WR_DESC: begin
				cmd.wr_desc = 1'b1;
				if (sts.wr_done) begin
					state_d = ST_EXH_LD;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				if (sts.out_free) begin
					state_d = sts.last_pos ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_EXH_LD: begin
				cmd.exh_ld = 1'b1;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/next_k_permutation_generator.sv =====
// ----------------------------------------------------------------------------
// next_k_permutation_generator
// Keeps an arrangement of item_count indices, the identity after reset. An
// input transaction with restart set reloads the identity and emits its
// first prefix_length entries; one with restart clear moves to the next
// arrangement whose prefix differs and emits that prefix, or emits one
// result flagged exhausted in tuser when none is left. Items are handled one
// at a time, and the block takes the next one while the last result still
// waits in the output register. An advance gathers the tail, walks left to
// find the pivot, steps the successor search one value at a time, rewrites
// the tail in ascending order and emits the prefix. Each sweep over the
// value mask visits at most MAX_ITEMS values. Each emitted result is read
// from the single read port of the permutation store and then loaded into
// the output register. Register writes take effect at the next input
// transaction.
// ----------------------------------------------------------------------------
module next_k_permutation_generator
	import nkpg_pkg::*;
#(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration writes.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] element, [7:4] position
	output logic                  m_tlast,
	output logic [0:0]            m_tuser    // [0] exhausted
);

	logic [CFG_W-1:0] item_count_q;
	logic [CFG_W-1:0] prefix_length_q;
	cmd_t             cmd;
	sts_t             sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q    <= ITEM_COUNT_RST;
			prefix_length_q <= PREFIX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ITEM_COUNT:    item_count_q    <= cfg_wdata;
				REG_PREFIX_LENGTH: prefix_length_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	nkpg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.restart (s_tdata[0]),
		.sts     (sts),
		.cmd     (cmd)
	);

	nkpg_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item_count   (item_count_q),
		.prefix_length(prefix_length_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser)
	);

	// The controller issues at most one command at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.sfx_rd, cmd.sfx_end, cmd.piv_rd, cmd.piv_cmp,
			cmd.succ, cmd.wr_asc, cmd.wr_desc, cmd.emit_rd, cmd.emit_ld, cmd.exh_ld}))
		else $error("more than one datapath command active");

	// An accepted transaction keeps the input side busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// A result loaded into a free output register is offered next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ld || cmd.exh_ld) && sts.out_free |=> m_tvalid)
		else $error("loaded result not offered");

	// The exhausted result stands alone and carries zero data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("malformed exhausted result");

endmodule
